### rtl/ppm_pkg.sv
package ppm_pkg;

  // fixed field widths
  localparam int unsigned PIN_W      = 8;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned SMP_W      = 16;
  localparam int unsigned VOLT_W     = 13;
  localparam int unsigned CFG_W      = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned MS_W       = 32;

  // defaults for the top level parameters
  localparam int unsigned DEF_MAX_CHANNELS = 16;
  localparam int unsigned DEF_ADC_BITS     = 10;

  // register reset values and saturation limit
  localparam logic [CFG_W-1:0]  POLL_RST = 16'd2000;
  localparam logic [CFG_W-1:0]  WIN_RST  = 16'd500;
  localparam logic [VOLT_W-1:0] VOLT_MAX = 13'd8191;

  typedef enum logic [1:0] {
    REQ_REGISTER = 2'd0,
    REQ_READ     = 2'd1,
    REQ_SAMPLE   = 2'd2,
    REQ_TICK     = 2'd3
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLL_PERIOD   = 1'b0,
    CFG_SAMPLE_WINDOW = 1'b1
  } cfg_idx_e;

  // token travelling along the cell row
  typedef struct packed {
    logic              vld;
    req_type_e         op;
    logic [PIN_W-1:0]  pin;
    logic [SMP_W-1:0]  smp;
    logic              smp_en;
    logic              found;
    logic              valid_res;
    logic [VOLT_W-1:0] volts;
  } ppm_tok_t;

  // window events broadcast to every cell
  typedef struct packed {
    logic open;
    logic close;
  } ppm_win_t;

endpackage

### rtl/ppm_if.sv
interface ppm_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [ppm_pkg::PIN_W-1:0]   pin;
  logic [ppm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, req_type, pin, sample, input ready);
  modport sink   (input valid, req_type, pin, sample, output ready);
endinterface

interface ppm_res_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       valid_res;
  logic [ppm_pkg::VOLT_W-1:0] volts_q10;

  modport source (output valid, found, valid_res, volts_q10, input ready);
  modport sink   (input valid, found, valid_res, volts_q10, output ready);
endinterface

interface ppm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppm_pkg::CFG_IDX_W-1:0] index;
  logic [ppm_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/multichannel_peak_to_peak_monitor.sv
// register, read and sample requests walk the row of MAX_CHANNELS cells one cell
//   per cycle while the row is not stalled; a new request, tick included, is taken
//   only once the previous one has left the row
// tick requests do not enter the row; a held read result stalls the row
// reset: asynchronous, active low; table empty, timer and window cleared,
//   poll period 2000, sample window 500; no clearing pass
module multichannel_peak_to_peak_monitor #(
  parameter int unsigned MAX_CHANNELS = ppm_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned ADC_BITS     = ppm_pkg::DEF_ADC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppm_req_if.sink   req_i,
  ppm_res_if.source res_o,
  ppm_cfg_if.sink   cfg_i
);
  import ppm_pkg::*;

  ppm_tok_t tok [MAX_CHANNELS+1];
  ppm_win_t win;
  logic     adv;

  // sequencing, timer and result register
  ppm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .cfg_i  (cfg_i),
    .tok_o  (tok[0]),
    .tail_i (tok[MAX_CHANNELS]),
    .adv_o  (adv),
    .win_o  (win)
  );

  // row of channel cells
  for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_cell
    ppm_cell #(
      .ADC_BITS (ADC_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .win_i  (win),
      .tok_i  (tok[g]),
      .tok_o  (tok[g+1])
    );
  end

endmodule

### rtl/ppm_cell.sv
module ppm_cell #(
  parameter int unsigned ADC_BITS = ppm_pkg::DEF_ADC_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ppm_pkg::ppm_win_t win_i,
  input  ppm_pkg::ppm_tok_t tok_i,
  output ppm_pkg::ppm_tok_t tok_o
);
  import ppm_pkg::*;

  localparam int unsigned MW = ADC_BITS + 1;
  localparam int unsigned PW = (ADC_BITS + 3 > VOLT_W) ? ADC_BITS + 3 : VOLT_W;
  localparam logic [MW-1:0] MinRst = {1'b1, {ADC_BITS{1'b0}}};

  logic              occ_q, occ_d;
  logic [PIN_W-1:0]  pin_q, pin_d;
  logic [MW-1:0]     min_q, min_d;
  logic [ADC_BITS-1:0] max_q, max_d;
  logic              rval_q, rval_d;
  logic [VOLT_W-1:0] volts_q, volts_d;
  ppm_tok_t          tok_q, tok_d;
  logic              tok_vld_q;

  logic                hit;
  logic [ADC_BITS-1:0] smp;
  logic [MW-1:0]       max_ext;
  logic [MW-1:0]       diff;
  logic [PW-1:0]       prod;
  logic [VOLT_W-1:0]   volts_new;

  // peak-to-peak of this channel, times five, clamped
  always_comb begin
    max_ext = {1'b0, max_q};
    diff    = max_ext - min_q;
    prod    = (PW'(diff[ADC_BITS-1:0]) << 2) + PW'(diff[ADC_BITS-1:0]);
    if (max_ext <= min_q) begin
      volts_new = '0;
    end else if (prod > PW'(VOLT_MAX)) begin
      volts_new = VOLT_MAX;
    end else begin
      volts_new = prod[VOLT_W-1:0];
    end
  end

  // channel update and token hand-over
  always_comb begin
    occ_d   = occ_q;
    pin_d   = pin_q;
    min_d   = min_q;
    max_d   = max_q;
    rval_d  = rval_q;
    volts_d = volts_q;
    tok_d   = tok_i;
    hit     = occ_q && (tok_i.pin == pin_q);
    smp     = tok_i.smp[ADC_BITS-1:0];

    if (win_i.close && occ_q) begin
      rval_d  = 1'b1;
      volts_d = volts_new;
    end
    if (win_i.open) begin
      min_d = MinRst;
      max_d = '0;
    end

    if (en_i && tok_i.vld) begin
      case (tok_i.op)
        REQ_REGISTER: begin
          // first free cell takes a pin that no earlier cell holds
          if (!occ_q && !tok_i.found) begin
            occ_d       = 1'b1;
            pin_d       = tok_i.pin;
            rval_d      = 1'b0;
            volts_d     = '0;
            min_d       = MinRst;
            max_d       = '0;
            tok_d.found = 1'b1;
          end else if (hit) begin
            tok_d.found = 1'b1;
          end
        end
        REQ_READ: begin
          if (hit) begin
            tok_d.found     = 1'b1;
            tok_d.valid_res = rval_q;
            tok_d.volts     = volts_q;
          end
        end
        REQ_SAMPLE: begin
          if (hit && tok_i.smp_en) begin
            if (smp > max_q) begin
              max_d = smp;
            end
            if ({1'b0, smp} < min_q) begin
              min_d = {1'b0, smp};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= 1'b0;
      rval_q    <= 1'b0;
      tok_vld_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      rval_q <= rval_d;
      if (en_i) begin
        tok_vld_q <= tok_d.vld;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pin_q   <= pin_d;
    min_q   <= min_d;
    max_q   <= max_d;
    volts_q <= volts_d;
    if (en_i) begin
      tok_q <= tok_d;
    end
  end

  // outgoing token with its reset valid bit
  always_comb begin
    tok_o     = tok_q;
    tok_o.vld = tok_vld_q;
  end

endmodule

### rtl/ppm_ctrl.sv
module ppm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  ppm_req_if.sink           req_i,
  ppm_res_if.source         res_o,
  ppm_cfg_if.sink           cfg_i,
  output ppm_pkg::ppm_tok_t tok_o,
  input  ppm_pkg::ppm_tok_t tail_i,
  output logic              adv_o,
  output ppm_pkg::ppm_win_t win_o
);
  import ppm_pkg::*;

  logic [CFG_W-1:0]  poll_q, poll_d;
  logic [CFG_W-1:0]  swin_q, swin_d;
  logic [MS_W-1:0]   ms_q, ms_d;
  logic [MS_W-1:0]   wstart_q, wstart_d;
  logic              inwin_q, inwin_d;
  logic [PIN_W-1:0]  sel_q, sel_d;
  logic              busy_q, busy_d;
  logic              ovld_q, ovld_d;
  logic              ofound_q, ofound_d;
  logic              ovalid_q, ovalid_d;
  logic [VOLT_W-1:0] ovolts_q, ovolts_d;

  req_type_e         op;
  logic              acc;
  logic              tick;
  logic [MS_W-1:0]   ms_inc;
  logic [MS_W-1:0]   el_now;
  logic [MS_W-1:0]   el_tick;
  logic              close_w;
  logic              open_w;
  logic              tail_read;
  logic              load_out;

  assign op    = req_type_e'(req_i.req_type);
  assign req_i.ready = !busy_q;
  assign acc   = req_i.valid && req_i.ready;
  assign tick  = acc && (op == REQ_TICK);
  assign cfg_i.ready = 1'b1;

  // window timing
  always_comb begin
    ms_inc  = ms_q + MS_W'(1);
    el_now  = ms_q - wstart_q;
    el_tick = ms_inc - wstart_q;
    close_w = tick && inwin_q && (el_tick >= MS_W'(swin_q));
    open_w  = tick && !(inwin_q && !close_w) && (el_tick > MS_W'(poll_q));
  end

  assign win_o.open  = open_w;
  assign win_o.close = close_w;

  // token into the first cell
  always_comb begin
    tok_o.vld       = acc && (op != REQ_TICK);
    tok_o.op        = op;
    tok_o.pin       = (op == REQ_READ) ? sel_q : req_i.pin;
    tok_o.smp       = SMP_W'(req_i.sample);
    tok_o.smp_en    = inwin_q && (el_now < MS_W'(swin_q));
    tok_o.found     = 1'b0;
    tok_o.valid_res = 1'b0;
    tok_o.volts     = '0;
  end

  // row holds while a read result cannot leave
  assign tail_read = tail_i.vld && (tail_i.op == REQ_READ);
  assign adv_o     = !(tail_read && ovld_q && !res_o.ready);
  assign load_out  = tail_read && adv_o;

  // next state
  always_comb begin
    poll_d   = poll_q;
    swin_d   = swin_q;
    ms_d     = ms_q;
    wstart_d = wstart_q;
    inwin_d  = inwin_q;
    sel_d    = sel_q;
    busy_d   = busy_q;
    ovld_d   = ovld_q;
    ofound_d = ofound_q;
    ovalid_d = ovalid_q;
    ovolts_d = ovolts_q;

    if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_POLL_PERIOD:   poll_d = cfg_i.data;
        CFG_SAMPLE_WINDOW: swin_d = cfg_i.data;
        default: begin
        end
      endcase
    end

    if (tick) begin
      ms_d = ms_inc;
      if (close_w) begin
        inwin_d = 1'b0;
      end
      if (open_w) begin
        inwin_d  = 1'b1;
        wstart_d = ms_inc;
      end
    end

    if (acc && (op == REQ_REGISTER)) begin
      sel_d = req_i.pin;
    end

    if (tok_o.vld) begin
      busy_d = 1'b1;
    end else if (tail_i.vld && adv_o) begin
      busy_d = 1'b0;
    end

    if (res_o.ready) begin
      ovld_d = 1'b0;
    end
    if (load_out) begin
      ovld_d   = 1'b1;
      ofound_d = tail_i.found;
      ovalid_d = tail_i.valid_res;
      ovolts_d = tail_i.volts;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_q   <= POLL_RST;
      swin_q   <= WIN_RST;
      ms_q     <= '0;
      wstart_q <= '0;
      inwin_q  <= 1'b0;
      sel_q    <= '0;
      busy_q   <= 1'b0;
      ovld_q   <= 1'b0;
    end else begin
      poll_q   <= poll_d;
      swin_q   <= swin_d;
      ms_q     <= ms_d;
      wstart_q <= wstart_d;
      inwin_q  <= inwin_d;
      sel_q    <= sel_d;
      busy_q   <= busy_d;
      ovld_q   <= ovld_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    ofound_q <= ofound_d;
    ovalid_q <= ovalid_d;
    ovolts_q <= ovolts_d;
  end

  assign res_o.valid     = ovld_q;
  assign res_o.found     = ofound_q;
  assign res_o.valid_res = ovalid_q;
  assign res_o.volts_q10 = ovolts_q;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import ppm_pkg::*;

  localparam int unsigned MAX_CH   = DEF_MAX_CHANNELS;
  localparam int unsigned POOL_N   = 24;
  localparam int unsigned SETTLE   = 2 * MAX_CH + 8;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned WD_LIMIT = 20000;
  localparam logic [SAMPLE_W:0] NO_SAMPLE_MIN = (SAMPLE_W + 1)'(1 << DEF_ADC_BITS);

  typedef struct {
    req_type_e           kind;
    logic [PIN_W-1:0]    pin;
    logic [SAMPLE_W-1:0] level;
  } request_t;

  typedef struct {
    logic              found;
    logic              valid_res;
    logic [VOLT_W-1:0] volts;
  } reading_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ppm_req_if req_bus ();
  ppm_res_if res_bus ();
  ppm_cfg_if cfg_bus ();

  multichannel_peak_to_peak_monitor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  always #2 clk_i = ~clk_i;

  // requests waiting to go out and readings waiting to come back
  request_t requests_to_send[$];
  reading_t readings_due[$];
  request_t on_bus;

  // own copy of the pin table, peak tracking and window timer
  logic [PIN_W-1:0]    tbl_pin [MAX_CH];
  int unsigned         n_ch;
  logic [SAMPLE_W:0]   lo [MAX_CH];
  logic [SAMPLE_W-1:0] hi [MAX_CH];
  logic                done [MAX_CH];
  logic [VOLT_W-1:0]   peak [MAX_CH];
  logic [PIN_W-1:0]    sel_pin;
  logic [MS_W-1:0]     now_ms;
  logic [MS_W-1:0]     win_open_ms;
  logic                measuring;
  logic [CFG_W-1:0]    poll_ms;
  logic [CFG_W-1:0]    window_ms;

  logic [PIN_W-1:0] pin_pool [POOL_N];
  bit steady;
  bit want_hold;
  int unsigned hold_cycles;
  int unsigned errors;
  int unsigned requests_done;
  int unsigned readings_checked;
  int unsigned windows_closed;
  int unsigned reg_writes;
  int unsigned quiet_cycles;

  function automatic int find_slot(logic [PIN_W-1:0] p);
    for (int i = 0; i < int'(n_ch); i++) begin
      if (tbl_pin[i] == p) return i;
    end
    return -1;
  endfunction

  // advance the peak tracker by one accepted request
  task automatic track_request(input request_t r);
    int slot;
    int d;
    logic [MS_W-1:0] elapsed;
    reading_t rd;
    case (r.kind)
      REQ_REGISTER: begin
        slot = find_slot(r.pin);
        if (slot < 0 && n_ch < MAX_CH) begin
          tbl_pin[n_ch] = r.pin;
          done[n_ch]    = 1'b0;
          peak[n_ch]    = '0;
          lo[n_ch]      = NO_SAMPLE_MIN;
          hi[n_ch]      = '0;
          n_ch++;
        end
        sel_pin = r.pin;
      end
      REQ_READ: begin
        slot = find_slot(sel_pin);
        if (slot < 0) begin
          rd = '{found: 1'b0, valid_res: 1'b0, volts: '0};
        end else begin
          rd = '{found: 1'b1, valid_res: done[slot], volts: peak[slot]};
        end
        readings_due.push_back(rd);
      end
      REQ_SAMPLE: begin
        slot = find_slot(r.pin);
        elapsed = now_ms - win_open_ms;
        if (slot >= 0 && measuring && elapsed < {16'd0, window_ms}) begin
          if ({1'b0, r.level} < lo[slot]) lo[slot] = {1'b0, r.level};
          if (r.level > hi[slot]) hi[slot] = r.level;
        end
      end
      default: begin
        now_ms = now_ms + 1;
        elapsed = now_ms - win_open_ms;
        // window end: latch peak-to-peak, empty channels clamp to zero
        if (measuring && elapsed >= {16'd0, window_ms}) begin
          measuring = 1'b0;
          for (int i = 0; i < int'(n_ch); i++) begin
            d = ({1'b0, hi[i]} > lo[i]) ? (int'(hi[i]) - int'(lo[i])) * 5 : 0;
            if (d > int'(VOLT_MAX)) d = int'(VOLT_MAX);
            done[i] = 1'b1;
            peak[i] = VOLT_W'(d);
          end
          windows_closed++;
        end
        // window start once the poll period is exceeded
        if (!measuring && elapsed > {16'd0, poll_ms}) begin
          win_open_ms = now_ms;
          measuring   = 1'b1;
          for (int i = 0; i < int'(MAX_CH); i++) begin
            lo[i] = NO_SAMPLE_MIN;
            hi[i] = '0;
          end
        end
      end
    endcase
  endtask

  // request driver
  always @(posedge clk_i) begin : drive_requests
    bit gap;
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid) begin
        track_request(on_bus);
        requests_done++;
      end
      gap = !steady && ($urandom_range(99) < 24);
      if (requests_to_send.size() != 0 && !gap) begin
        on_bus = requests_to_send.pop_front();
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= on_bus.kind;
        req_bus.pin      <= on_bus.pin;
        req_bus.sample   <= on_bus.level;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // result monitor and checker, with the one long hold-off
  always @(posedge clk_i) begin : check_readings
    reading_t want;
    if (!rst_ni) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (readings_due.size() == 0) begin
          $error("reading with no read request waiting: found %0d valid_res %0d volts_q10 %0d",
                 res_bus.found, res_bus.valid_res, res_bus.volts_q10);
          errors++;
        end else begin
          want = readings_due.pop_front();
          readings_checked++;
          if (res_bus.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, res_bus.found);
            errors++;
          end
          if (res_bus.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, res_bus.valid_res);
            errors++;
          end
          if (res_bus.volts_q10 !== want.volts) begin
            $error("volts_q10: expected %0d, got %0d", want.volts, res_bus.volts_q10);
            errors++;
          end
        end
      end
      if (want_hold && hold_cycles < HOLD_LEN) begin
        hold_cycles++;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WD_LIMIT) begin
      $display("no handshake for %0d cycles", WD_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_req(req_type_e k, logic [PIN_W-1:0] p, logic [SAMPLE_W-1:0] s);
    request_t r;
    r = '{kind: k, pin: p, level: s};
    requests_to_send.push_back(r);
  endtask

  // mostly pooled pins with a random mix of ticks, samples, reads and registers; some stray pins
  task automatic queue_random(int unsigned n);
    int unsigned pick;
    logic [PIN_W-1:0] p;
    logic [SAMPLE_W-1:0] s;
    for (int unsigned i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      p = ($urandom_range(99) < 80) ? pin_pool[$urandom_range(POOL_N - 1)]
                                    : PIN_W'($urandom_range(255));
      case ($urandom_range(9))
        0:       s = '0;
        1:       s = '1;
        default: s = SAMPLE_W'($urandom_range(1023));
      endcase
      if (pick < 8)       queue_req(REQ_REGISTER, p, s);
      else if (pick < 28) queue_req(REQ_READ, p, s);
      else if (pick < 62) queue_req(REQ_SAMPLE, p, s);
      else                queue_req(REQ_TICK, p, s);
    end
  endtask

  // wait until every request is taken and every reading is back
  task automatic drain();
    do @(negedge clk_i);
    while (requests_to_send.size() != 0 || req_bus.valid || readings_due.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    drain();
    repeat (SETTLE) @(posedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk_i);
    while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    if (idx == CFG_POLL_PERIOD) poll_ms = val;
    else window_ms = val;
    reg_writes++;
    @(negedge clk_i);
  endtask

  task automatic set_timing(logic [CFG_W-1:0] poll, logic [CFG_W-1:0] win);
    write_reg(CFG_POLL_PERIOD, poll);
    write_reg(CFG_SAMPLE_WINDOW, win);
  endtask

  // stimulus
  initial begin
    rst_ni           = 1'b0;
    req_bus.valid    = 1'b0;
    req_bus.req_type = REQ_TICK;
    req_bus.pin      = '0;
    req_bus.sample   = '0;
    res_bus.ready    = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_POLL_PERIOD;
    cfg_bus.data     = '0;
    n_ch        = 0;
    sel_pin     = '0;
    now_ms      = '0;
    win_open_ms = '0;
    measuring   = 1'b0;
    poll_ms     = POLL_RST;
    window_ms   = WIN_RST;
    for (int i = 0; i < int'(MAX_CH); i++) begin
      tbl_pin[i] = '0;
      lo[i]      = NO_SAMPLE_MIN;
      hi[i]      = '0;
      done[i]    = 1'b0;
      peak[i]    = '0;
    end
    for (int i = 0; i < int'(POOL_N); i++) pin_pool[i] = PIN_W'($urandom_range(255));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset timing: read before any pin, then pins with no window open
    queue_req(REQ_READ, 8'd0, 10'd0);
    queue_req(REQ_REGISTER, 8'd0, 10'd0);
    queue_req(REQ_READ, 8'd0, 10'd0);
    queue_req(REQ_SAMPLE, 8'd0, 10'd1023);
    queue_req(REQ_TICK, 8'd0, 10'd0);
    queue_req(REQ_REGISTER, 8'd255, 10'd1023);
    queue_req(REQ_SAMPLE, 8'd77, 10'd512);
    queue_req(REQ_READ, 8'd255, 10'd0);

    // short window: full-scale swing on one pin, no samples on the other
    set_timing(16'd0, 16'd2);
    queue_req(REQ_TICK, 8'd0, 10'd0);
    queue_req(REQ_SAMPLE, 8'd0, 10'd1023);
    queue_req(REQ_SAMPLE, 8'd0, 10'd0);
    queue_req(REQ_TICK, 8'd0, 10'd0);
    queue_req(REQ_TICK, 8'd0, 10'd0);
    queue_req(REQ_REGISTER, 8'd0, 10'd0);
    queue_req(REQ_READ, 8'd0, 10'd0);
    queue_req(REQ_REGISTER, 8'd255, 10'd0);
    queue_req(REQ_READ, 8'd0, 10'd0);

    // zero-length window closes at once and never reopens
    set_timing(16'hFFFF, 16'd0);
    queue_req(REQ_SAMPLE, 8'd0, 10'd700);
    queue_req(REQ_TICK, 8'd0, 10'd0);
    queue_req(REQ_REGISTER, 8'd0, 10'd0);
    queue_req(REQ_READ, 8'd0, 10'd0);

    set_timing(16'hFFFF, 16'hFFFF);
    queue_req(REQ_TICK, 8'd255, 10'd1023);
    queue_req(REQ_READ, 8'd0, 10'd0);

    // random phases over several timings
    set_timing(16'd5, 16'd4);
    queue_random(300);
    set_timing(16'($urandom_range(30)), 16'($urandom_range(20)));
    queue_random(300);
    set_timing(16'd3, 16'd8);
    steady = 1'b1;
    queue_random(300);
    drain();
    steady = 1'b0;
    set_timing(16'd10, 16'd6);
    queue_random(300);
    want_hold = 1'b1;
    set_timing(16'd0, 16'd1);
    queue_random(300);
    set_timing(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)));
    queue_random(300);

    drain();
    repeat (SETTLE) @(posedge clk_i);
    $display("%0d requests sent, %0d readings checked, %0d measuring windows closed",
             requests_done, readings_checked, windows_closed);
    $display("%0d register writes, %0d pins in the table at the end", reg_writes, n_ch);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
